// ===== hdl/ajb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ajb_pkg
// Types, codes and constants of the audio source jitter buffer.
// ----------------------------------------------------------------------------
package ajb_pkg;

  localparam int unsigned FIFO_DEPTH_DEF   = 8192;
  localparam int unsigned SAMPLE_W         = 32;
  localparam int unsigned LEVEL_W          = 14;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned CFG_DATA_W       = 14;
  localparam logic [13:0] PREBUF_RESET     = 14'd2048;

  localparam logic [CFG_IDX_W-1:0] CFG_A2DP_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREBUF     = 1'b1;

  typedef enum logic [1:0] {
    FUNC_STATUS = 2'd0,
    FUNC_FEED   = 2'd1,
    FUNC_TICK   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    SRC_IDLE = 2'd0,
    SRC_BT   = 2'd1,
    SRC_NET  = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    FEED_OK    = 2'd0,
    FEED_WRONG = 2'd1,
    FEED_FULL  = 2'd2,
    FEED_NONE  = 2'd3
  } feed_e;

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_PAUSE  = 2'd1,
    EVT_RESUME = 2'd2
  } pause_e;

  typedef struct packed {
    logic [1:0]          func;
    logic [1:0]          from_source;
    logic [SAMPLE_W-1:0] sample;
    logic                snap_active;
    logic                a2dp_connected;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out_sample;
    logic                played;
    logic [1:0]          feed_status;
    logic [1:0]          active_source;
    logic [1:0]          pause_event;
    logic                underrun;
    logic [LEVEL_W-1:0]  fill_level;
  } out_item_t;

  // result of one transaction, minus the frame data still in the ram
  typedef struct packed {
    logic               played;
    logic [1:0]         feed_status;
    logic [1:0]         active_source;
    logic [1:0]         pause_event;
    logic               underrun;
    logic [LEVEL_W-1:0] fill_level;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/ajb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ajb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ajb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/ajb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ajb_front
// Classifies transactions, keeps source, flags and fifo pointers, and issues
// frame store writes and reads.
// ----------------------------------------------------------------------------
module ajb_front #(
  parameter int unsigned FifoDepth = ajb_pkg::FIFO_DEPTH_DEF,
  localparam int unsigned AW = $clog2(FifoDepth),
  localparam int unsigned CW = $clog2(FifoDepth + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [ajb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ajb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             item_valid_i,
  input  wire ajb_pkg::in_item_t                in_item_i,
  output logic                                  ram_we_o,
  output logic      [AW-1:0]                    ram_waddr_o,
  output logic      [ajb_pkg::SAMPLE_W-1:0]     ram_wdata_o,
  output logic                                  ram_re_o,
  output logic      [AW-1:0]                    ram_raddr_o,
  output ajb_pkg::cmd_t                         cmd_o
);

  import ajb_pkg::*;

  localparam int unsigned TW = (CW > LEVEL_W) ? CW : LEVEL_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(FifoDepth - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(FifoDepth);
  localparam logic [TW-1:0] DEPTH_T  = TW'(FifoDepth);

  logic               a2dp_first_q;
  logic [LEVEL_W-1:0] prebuf_q;
  logic [AW-1:0]      rp_q, rp_d;
  logic [AW-1:0]      wp_q, wp_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic [1:0]         src_q, src_d;
  logic               net_q, net_d;
  logic               bt_q, bt_d;
  logic               ready_q, ready_d;

  logic [1:0]         want;
  logic [TW-1:0]      prebuf_t;
  logic [TW-1:0]      thr;
  logic               wait_play;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a2dp_first_q <= 1'b1;
      prebuf_q     <= PREBUF_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_A2DP_FIRST: a2dp_first_q <= cfg_data_i[0];
        CFG_PREBUF:     prebuf_q     <= cfg_data_i[LEVEL_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    want = SRC_IDLE;
    if (a2dp_first_q) begin
      if (bt_q)       want = SRC_BT;
      else if (net_q) want = SRC_NET;
    end else begin
      if (net_q)      want = SRC_NET;
      else if (bt_q)  want = SRC_BT;
    end
  end

  assign prebuf_t = TW'(prebuf_q);
  assign thr      = (prebuf_t > DEPTH_T) ? DEPTH_T : prebuf_t;

  always_comb begin
    rp_d      = rp_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    src_d     = src_q;
    net_d     = net_q;
    bt_d      = bt_q;
    ready_d   = ready_q;
    wait_play = 1'b0;

    ram_we_o    = 1'b0;
    ram_waddr_o = wp_q;
    ram_wdata_o = in_item_i.sample;
    ram_re_o    = 1'b0;
    ram_raddr_o = rp_q;

    cmd_o               = '0;
    cmd_o.feed_status   = FEED_NONE;
    cmd_o.pause_event   = EVT_NONE;

    case (in_item_i.func)
      FUNC_STATUS: begin
        net_d = in_item_i.snap_active;
        bt_d  = in_item_i.a2dp_connected;
      end
      FUNC_FEED: begin
        if (src_q == SRC_IDLE || in_item_i.from_source != src_q) begin
          cmd_o.feed_status = FEED_WRONG;
        end else if (fill_q >= DEPTH_C) begin
          cmd_o.feed_status = FEED_FULL;
        end else begin
          cmd_o.feed_status = FEED_OK;
          ram_we_o = item_valid_i;
          wp_d     = (wp_q == LAST_IDX) ? '0 : wp_q + AW'(1);
          fill_d   = fill_q + CW'(1);
        end
      end
      FUNC_TICK: begin
        if (want != src_q) begin
          rp_d    = '0;
          wp_d    = '0;
          fill_d  = '0;
          src_d   = want;
          ready_d = (want != SRC_NET);
          if (want == SRC_BT)       cmd_o.pause_event = EVT_PAUSE;
          else if (src_q == SRC_BT) cmd_o.pause_event = EVT_RESUME;
        end
        if (src_d == SRC_IDLE) begin
          wait_play = 1'b1;
        end else if (src_d == SRC_NET && !ready_d) begin
          if (TW'(fill_d) < thr) wait_play = 1'b1;
          else                   ready_d   = 1'b1;
        end
        if (!wait_play) begin
          if (fill_d == '0) begin
            cmd_o.underrun = 1'b1;
            if (src_d == SRC_NET) ready_d = 1'b0;
          end else begin
            ram_raddr_o  = rp_d;
            ram_re_o     = item_valid_i;
            cmd_o.played = 1'b1;
            rp_d   = (rp_d == LAST_IDX) ? '0 : rp_d + AW'(1);
            fill_d = fill_d - CW'(1);
          end
        end
      end
      default: ;
    endcase

    cmd_o.active_source = src_d;
    cmd_o.fill_level    = LEVEL_W'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q    <= '0;
      wp_q    <= '0;
      fill_q  <= '0;
      src_q   <= SRC_IDLE;
      net_q   <= 1'b0;
      bt_q    <= 1'b0;
      ready_q <= 1'b0;
    end else if (item_valid_i) begin
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      src_q   <= src_d;
      net_q   <= net_d;
      bt_q    <= bt_d;
      ready_q <= ready_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ajb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ajb_back
// Joins each classified transaction with its frame from the store and keeps
// finished results in a short queue for the consumer.
// ----------------------------------------------------------------------------
module ajb_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire ajb_pkg::cmd_t                 cmd_i,
  input  wire logic [ajb_pkg::SAMPLE_W-1:0]  rdata_i,
  output logic                               full_o,
  output logic                               empty_o,
  input  wire logic                          pop_i,
  output ajb_pkg::out_item_t                 out_item_o
);

  import ajb_pkg::*;

  localparam int unsigned QD  = 4;
  localparam int unsigned QAW = $clog2(QD);
  localparam int unsigned QCW = $clog2(QD + 1);

  logic             stg_valid_q;
  cmd_t             stg_cmd_q;
  out_item_t        q_mem_q [QD];
  logic [QAW-1:0]   wr_ptr_q;
  logic [QAW-1:0]   rd_ptr_q;
  logic [QCW-1:0]   count_q, count_d;
  logic             do_pop;
  out_item_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      stg_cmd_q <= cmd_i;
    end
  end

  // frame data arrives from the ram together with the staged command
  always_comb begin
    res.out_sample    = stg_cmd_q.played ? rdata_i : '0;
    res.played        = stg_cmd_q.played;
    res.feed_status   = stg_cmd_q.feed_status;
    res.active_source = stg_cmd_q.active_source;
    res.pause_event   = stg_cmd_q.pause_event;
    res.underrun      = stg_cmd_q.underrun;
    res.fill_level    = stg_cmd_q.fill_level;
  end

  assign do_pop = pop_i && !empty_o;

  always_comb begin
    count_d = count_q;
    if (stg_valid_q && !do_pop)      count_d = count_q + QCW'(1);
    else if (!stg_valid_q && do_pop) count_d = count_q - QCW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (stg_valid_q) wr_ptr_q <= wr_ptr_q + QAW'(1);
      if (do_pop)      rd_ptr_q <= rd_ptr_q + QAW'(1);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_valid_q) begin
      q_mem_q[wr_ptr_q] <= res;
    end
  end

  // room is kept for the transaction still in the staging register
  assign full_o     = (count_q + QCW'(stg_valid_q)) >= QCW'(QD);
  assign empty_o    = (count_q == '0);
  assign out_item_o = q_mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== hdl/audio_source_jitter_buffer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// audio_source_jitter_buffer
// Two-source audio arbiter with a per-frame jitter fifo and prebuffering.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     push / full               in_item_i   (ajb_pkg::in_item_t)
//  result    pop / empty               out_item_o  (ajb_pkg::out_item_t)
//  config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  one transaction per cycle while full is low; a result enters the queue from
//  the staging register, which holds it while the frame store read lands
//  full is high once queued results plus the staged one reach four
//  reset clears source, flags, pointers and queue; frame store is not cleared
//  and needs no clearing pass, config ready is always high
// ----------------------------------------------------------------------------
module audio_source_jitter_buffer #(
  parameter int unsigned FifoDepth = ajb_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire ajb_pkg::in_item_t               in_item_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output ajb_pkg::out_item_t                   out_item_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ajb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ajb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import ajb_pkg::*;

  localparam int unsigned AW = $clog2(FifoDepth);

  logic                accept;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  cmd_t                cmd;

  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  ajb_front #(
    .FifoDepth (FifoDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (accept),
    .in_item_i    (in_item_i),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .cmd_o        (cmd)
  );

  ajb_ram #(
    .Width (SAMPLE_W),
    .Depth (FifoDepth)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ajb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (accept),
    .cmd_i       (cmd),
    .rdata_i     (ram_rdata),
    .full_o      (full),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire
